[design/wpm_pkg.sv]
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants of the wildcard pattern matcher: action codes,
// wildcard byte codes, lane geometry of the row update and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

   // request action codes
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_TEXT  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   // wildcard bytes
   localparam logic [7:0] STAR_BYTE = 8'd42;
   localparam logic [7:0] ANY_BYTE  = 8'd63;

   // pattern positions handled per row update cycle
   localparam int LANES  = 8;
   localparam int LANE_W = 3;

   // controller to datapath
   typedef struct packed {
      logic load;        // store a pattern byte
      logic restart;     // start a new pattern before storing
      logic close;       // set the row to its empty-text value
      logic latch;       // capture text symbol and final flag
      logic step;        // update one chunk of the row
      logic emit;        // load the response registers
      logic emit_query;  // response is the empty-text match
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_chunk;  // current chunk covers the last pattern position
   } status_type;

endpackage

`default_nettype wire

[design/wpm_ctrl.sv]
// ----------------------------------------------------------------------------
// wpm_ctrl
// Controller of the wildcard pattern matcher. Decodes accepted beats,
// tracks pattern loading, steps the row update chunk by chunk and owns the
// response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [1:0]           req_action,
   input  wire logic                 req_final_element,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      wpm_pkg::cmd_type     cmd,
   input  wire wpm_pkg::status_type  status
);

   typedef enum logic [1:0] {S_IDLE, S_CLOSE, S_TEXT, S_RESULT} state_type;

   state_type state_ff, state_in;
   logic      loading_ff, loading_in;
   logic      query_ff, query_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      loading_in = loading_ff;
      query_in   = query_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  wpm_pkg::ACT_LOAD: begin
                     cmd.load    = 1'b1;
                     cmd.restart = !loading_ff;
                     loading_in  = 1'b1;
                     if (req_final_element) begin
                        state_in = S_CLOSE;
                     end
                  end
                  wpm_pkg::ACT_TEXT: begin
                     cmd.latch  = 1'b1;
                     cmd.close  = loading_ff;
                     loading_in = 1'b0;
                     query_in   = 1'b0;
                     state_in   = S_TEXT;
                  end
                  wpm_pkg::ACT_QUERY: begin
                     cmd.latch  = 1'b1;
                     cmd.close  = loading_ff;
                     loading_in = 1'b0;
                     query_in   = 1'b1;
                     state_in   = S_RESULT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLOSE: begin
            cmd.close  = 1'b1;
            loading_in = 1'b0;
            state_in   = S_IDLE;
         end
         S_TEXT: begin
            cmd.step = 1'b1;
            if (status.last_chunk) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_query = query_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid: set on emit, cleared when the beat is taken
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loading_ff   <= 1'b1;
         query_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loading_ff   <= loading_in;
         query_ff     <= query_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[design/wpm_datapath.sv]
// ----------------------------------------------------------------------------
// wpm_datapath
// Datapath of the wildcard pattern matcher: pattern store, empty-text row
// built while loading, match row updated one chunk of lanes per cycle with a
// carry across chunks, and the response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_datapath #(
   parameter int MAX_PATTERN = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wpm_pkg::cmd_type     cmd,
   output      wpm_pkg::status_type  status,
   input  wire logic [7:0]           req_symbol,
   input  wire logic                 req_final_element,
   output      logic                 rsp_matched,
   output      logic                 rsp_end_of_text,
   output      logic                 rsp_pattern_overflow
);

   localparam int LW  = $clog2(MAX_PATTERN + 1);
   localparam int AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int NCH = (MAX_PATTERN + wpm_pkg::LANES - 1) / wpm_pkg::LANES;
   localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int PW  = NCH * wpm_pkg::LANES;
   localparam int BW  = CW + wpm_pkg::LANE_W;
   localparam int L   = wpm_pkg::LANES;

   logic [7:0]             pat_ff [MAX_PATTERN];
   logic [LW-1:0]          len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic                   allstar_ff, allstar_in;
   logic [MAX_PATTERN:0]   ir_ff, ir_in;
   logic [MAX_PATTERN:0]   row_ff, row_in;
   logic [7:0]             sym_ff;
   logic                   last_ff;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   bnd_ff, bnd_in;
   logic                   carry_ff, carry_in;
   logic                   rsp_matched_ff, rsp_eot_ff, rsp_ovf_ff;

   logic [LW-1:0]          eff_len;
   logic                   eff_all;
   logic                   store;
   logic                   is_star;

   logic [PW-1:0]          star_p, eq_p, act_p;
   logic [PW:0]            row_p, row_p_in;
   logic [BW-1:0]          base, base1;
   logic [L-1:0]           s_c, e_c, a_c, nx;
   logic [L:0]             r_c;
   logic                   bnd_sel, c_run, prev;
   logic [LW-1:0]          len_m1;
   logic [CW-1:0]          last_idx;

   // per-position compare cells
   for (genvar i = 0; i < PW; i++) begin : g_pos
      if (i < MAX_PATTERN) begin : g_live
         assign star_p[i] = (pat_ff[i] == wpm_pkg::STAR_BYTE);
         assign eq_p[i]   = (pat_ff[i] == wpm_pkg::ANY_BYTE) || (pat_ff[i] == sym_ff);
         assign act_p[i]  = (len_ff > LW'(i));
      end else begin : g_pad
         assign star_p[i] = 1'b0;
         assign eq_p[i]   = 1'b0;
         assign act_p[i]  = 1'b0;
      end
   end

   // pattern load: empty-text row and all-star flag follow each stored byte
   always_comb begin
      eff_len    = cmd.restart ? '0 : len_ff;
      eff_all    = cmd.restart || allstar_ff;
      store      = (eff_len != LW'(MAX_PATTERN));
      is_star    = (req_symbol == wpm_pkg::STAR_BYTE);
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      allstar_in = allstar_ff;
      ir_in      = ir_ff;
      if (cmd.load) begin
         ir_in  = cmd.restart ? (MAX_PATTERN + 1)'(1) : ir_ff;
         ovf_in = (!store) || (!cmd.restart && ovf_ff);
         if (store) begin
            len_in                     = eff_len + LW'(1);
            ir_in[eff_len + LW'(1)]    = eff_all && is_star;
            allstar_in                 = eff_all && is_star;
         end else begin
            len_in     = eff_len;
            allstar_in = eff_all;
         end
      end
   end

   // one chunk of the row update, star runs carried lane to lane
   always_comb begin
      row_p                   = '0;
      row_p[MAX_PATTERN:0]    = row_ff;
      base                    = {cnt_ff, {wpm_pkg::LANE_W{1'b0}}};
      base1                   = base + BW'(1);
      s_c                     = star_p[base +: L];
      e_c                     = eq_p[base +: L];
      a_c                     = act_p[base +: L];
      r_c                     = row_p[base +: (L + 1)];
      bnd_sel                 = (cnt_ff == '0) ? r_c[0] : bnd_ff;
      c_run                   = (cnt_ff == '0) ? 1'b0 : carry_ff;
      prev                    = 1'b0;
      nx                      = '0;
      for (int k = 0; k < L; k++) begin
         prev  = (k == 0) ? bnd_sel : r_c[k];
         nx[k] = a_c[k] && (s_c[k] ? (r_c[k + 1] || c_run) : (e_c[k] && prev));
         c_run = nx[k];
      end
      row_p_in             = row_p;
      row_p_in[base1 +: L] = nx;
      if (cnt_ff == '0) begin
         row_p_in[0] = 1'b0;
      end
   end

   // last chunk index from the pattern length
   assign len_m1            = len_ff - LW'(1);
   assign last_idx          = (len_ff == '0) ? '0 : CW'(len_m1 >> wpm_pkg::LANE_W);
   assign status.last_chunk = (cnt_ff == last_idx);

   // row and chunk sequencing
   always_comb begin
      row_in   = row_ff;
      cnt_in   = cnt_ff;
      bnd_in   = bnd_ff;
      carry_in = carry_ff;
      if (cmd.close) begin
         row_in = ir_ff;
      end
      if (cmd.latch) begin
         cnt_in = '0;
      end
      if (cmd.step) begin
         row_in   = row_p_in[MAX_PATTERN:0];
         cnt_in   = cnt_ff + CW'(1);
         bnd_in   = r_c[L];
         carry_in = nx[L-1];
      end
      if (cmd.emit && !cmd.emit_query && last_ff) begin
         row_in = ir_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         ovf_ff     <= 1'b0;
         allstar_ff <= 1'b1;
         ir_ff      <= (MAX_PATTERN + 1)'(1);
         row_ff     <= (MAX_PATTERN + 1)'(1);
         cnt_ff     <= '0;
      end else begin
         len_ff     <= len_in;
         ovf_ff     <= ovf_in;
         allstar_ff <= allstar_in;
         ir_ff      <= ir_in;
         row_ff     <= row_in;
         cnt_ff     <= cnt_in;
      end
   end

   // pattern store
   always_ff @(posedge clock) begin
      if (cmd.load && store) begin
         pat_ff[eff_len[AW-1:0]] <= req_symbol;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bnd_ff   <= bnd_in;
      carry_ff <= carry_in;
      if (cmd.latch) begin
         sym_ff  <= req_symbol;
         last_ff <= req_final_element;
      end
      if (cmd.emit) begin
         rsp_matched_ff <= cmd.emit_query ? allstar_ff : row_ff[len_ff];
         rsp_eot_ff     <= cmd.emit_query || last_ff;
         rsp_ovf_ff     <= ovf_ff;
      end
   end

   assign rsp_matched          = rsp_matched_ff;
   assign rsp_end_of_text      = rsp_eot_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

[design/wildcard_pattern_matcher.sv]
// Pattern byte: taken on accept; the last pattern byte then holds the block in a close state.
// Text byte: the row update walks the stored pattern 8 positions per cycle, then the
// response is registered once the output is free; the next beat is taken after that.
// Empty-text query: no row update; the response is registered once the output is free.
// Synchronous reset clears length and overflow, sets the match row to its empty-pattern value
// and starts pattern loading; the pattern store itself is not cleared.
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Streams text bytes against a loaded wildcard pattern ('*' any run, '?' any
// one byte) and reports after each text byte whether the text so far matches.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher #(
   parameter int MAX_PATTERN = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_final_element,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_matched,
   output      logic       rsp_end_of_text,
   output      logic       rsp_pattern_overflow
);

   wpm_pkg::cmd_type    cmd;
   wpm_pkg::status_type status;

   // sequencing
   wpm_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_final_element (req_final_element),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .cmd               (cmd),
      .status            (status)
   );

   // pattern store and match row
   wpm_datapath #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_symbol           (req_symbol),
      .req_final_element    (req_final_element),
      .rsp_matched          (rsp_matched),
      .rsp_end_of_text      (rsp_end_of_text),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

endmodule

`default_nettype wire
